// ===== rtl/core/sorted_insert_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_defines
// Assertion macros for the sorted insertion priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, clocked on i_clk, off during reset
`define SIPQ_ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("sipq assertion failed");

// next-cycle implication
`define SIPQ_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("sipq assertion failed");

`else

`define SIPQ_ASSERT_IMPL(lbl, ante, cons)
`define SIPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/sipq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the sorted insertion priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 20;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam int CAP_BITS    = 5;
    localparam int OCC_BITS    = 5;
    localparam int STATUS_BITS = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic ins;   // sorted insert of the new item
        logic deq;   // shift every entry one place toward the head
    } t_cell_ctl;

endpackage

// ===== rtl/core/sipq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_cell
// One entry of the sorted row: holds a key and payload, decides locally
// whether it keeps its entry, takes the new item or takes a neighbor's.
// ----------------------------------------------------------------------------
module sipq_cell #(
    parameter int KEY_BITS     = sipq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = sipq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  sipq_pkg::t_cell_ctl     i_ctl,
    input  logic                    i_occ,        // cell holds a live entry
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic                    i_prev_keep,  // neighbor toward head keeps
    input  logic [KEY_BITS-1:0]     i_prev_key,
    input  logic [PAYLOAD_BITS-1:0] i_prev_payload,
    input  logic [KEY_BITS-1:0]     i_next_key,
    input  logic [PAYLOAD_BITS-1:0] i_next_payload,
    output logic                    o_keep,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload
);
    import sipq_pkg::*;

    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_payload;

    // equal keys stay ahead of the new item
    assign o_keep    = i_occ && (r_key <= i_new_key);
    assign o_key     = r_key;
    assign o_payload = r_payload;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_key     = i_new_key;
                n_payload = i_new_payload;
            end else begin
                n_key     = i_prev_key;
                n_payload = i_prev_payload;
            end
        end else if (i_ctl.deq) begin
            n_key     = i_next_key;
            n_payload = i_next_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

endmodule

// ===== rtl/core/sorted_insert_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue kept sorted in a row of cells, head at cell zero.
// ----------------------------------------------------------------------------
// Takes one operation per clock: every cell compares its key with the new key
// in parallel and the whole row shifts or inserts in the same cycle, so the
// only state that sets the rate is the row, the entry count and the output
// register. The result is registered when the item is taken, and
// a new item is taken in the cycle a waiting result leaves, giving one item
// per cycle while the downstream side is ready. Equal keys leave in arrival
// order. No clearing pass runs after reset; cells past the count hold junk
// that is never shown.
// ----------------------------------------------------------------------------
`include "sorted_insert_priority_queue_defines.svh"

module sorted_insert_priority_queue #(
    parameter int DEPTH        = sipq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = sipq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = sipq_pkg::PAYLOAD_BITS_DEF,
    localparam int IN_TDATA_W  = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W =
        ((KEY_BITS + PAYLOAD_BITS + sipq_pkg::OCC_BITS + 7) / 8) * 8,
    localparam int OUT_TUSER_W = 1 + sipq_pkg::STATUS_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,  // item_key, item_payload
    input  logic [0:0]                        s_axis_tuser,  // operation
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_TDATA_W-1:0]            m_axis_tdata,  // out_key, out_payload, occupancy
    output logic [OUT_TUSER_W-1:0]            m_axis_tuser,  // out_valid, status
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sipq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sipq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sipq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import sipq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    // configuration
    logic [CAP_BITS-1:0]   r_cap;
    logic [CAP_BITS-1:0]   w_cap_min1;
    logic                  w_reg_hit;

    // queue control
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CMPW-1:0]       w_count_ext;
    logic                  w_accept;
    t_op                   w_op;
    logic [KEY_BITS-1:0]   w_new_key;
    logic [PAYLOAD_BITS-1:0] w_new_payload;
    logic                  w_full;
    logic                  w_empty;
    t_cell_ctl             w_ctl;

    // cell row
    logic                    w_occ     [DEPTH];
    logic                    w_keep    [DEPTH];
    logic [KEY_BITS-1:0]     w_key     [DEPTH];
    logic [PAYLOAD_BITS-1:0] w_payload [DEPTH];

    // output register
    logic                    r_out_vld;
    logic                    r_res_valid;
    logic [KEY_BITS-1:0]     r_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_payload;
    t_status                 r_res_status;
    logic [OCC_BITS-1:0]     r_res_occ;
    t_status                 n_res_status;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
    assign prdata    = w_reg_hit ? APB_DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_cap <= pwdata[CAP_BITS-1:0];
        end
    end

    // capacity zero acts as one; above DEPTH the count check caps it
    assign w_cap_min1 = (r_cap == '0) ? CAP_BITS'(1) : r_cap;

    // ------------------------------------------------------------ control
    assign s_axis_tready = !r_out_vld || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser[0]);
    assign w_new_key     = s_axis_tdata[KEY_BITS-1:0];
    assign w_new_payload = s_axis_tdata[KEY_BITS +: PAYLOAD_BITS];

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count >= CW'(DEPTH)) ||
                     (CMPW'(r_count) >= CMPW'(w_cap_min1));

    always_comb begin
        w_ctl        = '0;
        n_count      = r_count;
        n_res_status = ST_DONE;
        if (w_accept) begin
            case (w_op)
                OP_ENQ: begin
                    if (w_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
                OP_DEQ: begin
                    if (w_empty) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        w_ctl.deq = 1'b1;
                        n_count   = r_count - CW'(1);
                    end
                end
                default: begin
                    n_res_status = ST_DONE;
                end
            endcase
        end
    end

    assign w_count_ext = CMPW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ----------------------------------------------------------- cell row
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                    w_pk;
        logic [KEY_BITS-1:0]     w_pkey;
        logic [PAYLOAD_BITS-1:0] w_ppay;
        logic [KEY_BITS-1:0]     w_nkey;
        logic [PAYLOAD_BITS-1:0] w_npay;

        assign w_occ[k] = (CW'(k) < r_count);

        if (k == 0) begin : g_head
            assign w_pk   = 1'b1;
            assign w_pkey = w_new_key;
            assign w_ppay = w_new_payload;
        end else begin : g_body
            assign w_pk   = w_keep[k-1];
            assign w_pkey = w_key[k-1];
            assign w_ppay = w_payload[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_nkey = w_key[k];
            assign w_npay = w_payload[k];
        end else begin : g_mid
            assign w_nkey = w_key[k+1];
            assign w_npay = w_payload[k+1];
        end

        sipq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_occ          (w_occ[k]),
            .i_new_key      (w_new_key),
            .i_new_payload  (w_new_payload),
            .i_prev_keep    (w_pk),
            .i_prev_key     (w_pkey),
            .i_prev_payload (w_ppay),
            .i_next_key     (w_nkey),
            .i_next_payload (w_npay),
            .o_keep         (w_keep[k]),
            .o_key          (w_key[k]),
            .o_payload      (w_payload[k])
        );
    end

    // ------------------------------------------------------ result output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_accept) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_valid   <= w_ctl.deq;
            r_res_key     <= w_ctl.deq ? w_key[0]     : '0;
            r_res_payload <= w_ctl.deq ? w_payload[0] : '0;
            r_res_status  <= n_res_status;
            r_res_occ     <= w_count_ext[OCC_BITS-1:0];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'({r_res_occ, r_res_payload, r_res_key});
    assign m_axis_tuser  = {r_res_status, r_res_valid};

    // --------------------------------------------------------- assertions
    `SIPQ_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `SIPQ_ASSERT_IMPL(a_head_sorted, r_count >= CW'(2), w_key[0] <= w_key[1])
    `SIPQ_ASSERT_NEXT(a_deq_count, w_ctl.deq, (r_count + CW'(1)) == $past(r_count))
    `SIPQ_ASSERT_IMPL(a_valid_done, r_out_vld && r_res_valid, r_res_status == ST_DONE)

endmodule

// ===== tb/sorted_insert_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_test
// Self-checking bench for the sorted insertion priority queue.
// A short table of directed operations covers the empty and full statuses,
// key extremes, FIFO order among equal keys and odd capacity settings. Random
// enqueue/dequeue runs follow under several capacities. Every result item is
// checked against a sorted-list model of the queue, or for typed table rows
// against the result given in the table, with bursty input traffic, output
// stalls and one long output hold-off that backs up the input.
module sorted_insert_priority_queue_test;
    import sipq_pkg::*;

    localparam int KW    = KEY_BITS_DEF;
    localparam int PW    = PAYLOAD_BITS_DEF;
    localparam int OW    = OCC_BITS;
    localparam int IN_W  = ((KW + PW + 7) / 8) * 8;
    localparam int OUT_W = ((KW + PW + OW + 7) / 8) * 8;
    localparam int PER_PHASE = 118;

    typedef struct {
        logic [KW-1:0] key;
        logic [PW-1:0] pay;
    } entry_t;

    typedef struct {
        logic          valid;
        logic [KW-1:0] key;
        logic [PW-1:0] pay;
        t_status       status;
        logic [OW-1:0] occ;
    } result_t;

    typedef struct {
        bit            is_cfg;
        logic [31:0]   cfg_val;
        t_op           op;
        logic [KW-1:0] key;
        logic [PW-1:0] pay;
        bit            typed;
        result_t       want;
    } plan_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;   // item_key, item_payload
    logic [0:0]         s_axis_tuser = '0;   // operation
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;        // out_key, out_payload, occupancy
    logic [2:0]         m_axis_tuser;        // out_valid, status
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic               pready;

    entry_t        sorted_entries[$];
    result_t       due_results[$];
    logic [4:0]    cap_reg = CAP_RESET;
    int            mismatches = 0;
    int            results_seen = 0;
    int            burst_left = 0;
    plan_row_t     plan[$];
    int unsigned   phase_caps[8] = '{16, 1, 31, 5, 0, 2, 12, 16};

    sorted_insert_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one operation applied to the sorted list; equal keys stay behind older ones
    function automatic result_t queue_step(t_op op, logic [KW-1:0] key,
                                           logic [PW-1:0] pay);
        result_t r;
        entry_t  e;
        int      lim;
        int      pos;
        r.valid  = 1'b0;
        r.key    = '0;
        r.pay    = '0;
        r.status = ST_DONE;
        lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg));
        if (op == OP_ENQ) begin
            if (sorted_entries.size() >= lim) begin
                r.status = ST_FULL;
            end else begin
                pos = sorted_entries.size();
                while (pos > 0 && key < sorted_entries[pos-1].key)
                    pos--;
                e.key = key;
                e.pay = pay;
                sorted_entries.insert(pos, e);
            end
        end else if (sorted_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e = sorted_entries.pop_front();
            r.valid = 1'b1;
            r.key   = e.key;
            r.pay   = e.pay;
        end
        r.occ = OW'(sorted_entries.size());
        return r;
    endfunction

    function automatic logic [KW-1:0] pick_key();
        case ($urandom_range(0, 7))
            0, 1: return KW'($urandom_range(0, 7));   // dense keys, many ties
            2:    return $urandom_range(0, 1) ? {KW{1'b1}} : {KW{1'b0}};
            default: return KW'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0h want %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // offer one item in bursty fashion, then log what it should produce
    task automatic push_item(t_op op, logic [KW-1:0] key, logic [PW-1:0] pay,
                             bit typed, result_t want);
        int      gap;
        result_t r;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({pay, key});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        r = queue_step(op, key, pay);
        due_results.push_back(typed ? want : r);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cap(logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = val[4:0];
    endtask

    // result checker
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                flag_mismatch("unexpected item, key", m_axis_tdata[KW-1:0], 0);
            end else begin
                want = due_results.pop_front();
                if (m_axis_tuser[0] !== want.valid)
                    flag_mismatch("out_valid", m_axis_tuser[0], want.valid);
                if (m_axis_tuser[2:1] !== want.status)
                    flag_mismatch("status", m_axis_tuser[2:1], want.status);
                if (m_axis_tdata[KW-1:0] !== want.key)
                    flag_mismatch("out_key", m_axis_tdata[KW-1:0], want.key);
                if (m_axis_tdata[KW+PW-1:KW] !== want.pay)
                    flag_mismatch("out_payload", m_axis_tdata[KW+PW-1:KW], want.pay);
                if (m_axis_tdata[KW+PW+OW-1:KW+PW] !== want.occ)
                    flag_mismatch("occupancy", m_axis_tdata[KW+PW+OW-1:KW+PW], want.occ);
            end
            results_seen <= results_seen + 1;
        end
    end

    // output side: stall mix that changes every so often, plus one long hold-off
    initial begin : rx_pattern
        int span;
        int pct;
        int hold_left;
        bit held_once;
        span = 0;
        pct = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && results_seen >= 500) begin
                held_once = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (span == 0) begin
                    span = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 15;
                        2: pct = 50;
                        default: pct = 85;
                    endcase
                end
                span--;
                m_axis_tready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    initial begin : stimulus
        int   enq_pct;
        t_op  op;
        // op, key, payload; typed rows carry the result that is plain to see
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 1, '{0, 0, 0, ST_EMPTY, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'hFFFFF, 16'hFFFF, 1, '{0, 0, 0, ST_DONE, 1}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00005, 16'hAAAA, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00005, 16'h5555, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 1, '{1, 0, 0, ST_DONE, 3}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        // capacity zero acts as one
        plan.push_back('{1, 0, OP_ENQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h12345, 16'h0F0F, 1, '{0, 0, 0, ST_FULL, 1}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 1,
                         '{1, 20'hFFFFF, 16'hFFFF, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h12345, 16'h0F0F, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00000, 16'hFFFF, 1, '{0, 0, 0, ST_FULL, 1}});
        // capacity above the depth saturates
        plan.push_back('{1, 31, OP_ENQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h80000, 16'h1234, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00001, 16'h8001, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h80000, 16'h4321, 0, '{0, 0, 0, ST_DONE, 0}});
        // capacity dropped under the count: nothing lost, enqueues refused
        plan.push_back('{1, 2, OP_ENQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00007, 16'h7777, 1, '{0, 0, 0, ST_FULL, 4}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00000, 16'h0001, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_ENQ, 20'h00000, 16'h0002, 1, '{0, 0, 0, ST_FULL, 2}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 0, '{0, 0, 0, ST_DONE, 0}});
        plan.push_back('{0, 0, OP_DEQ, 20'h00000, 16'h0000, 1, '{0, 0, 0, ST_EMPTY, 0}});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_cap(plan[i].cfg_val);
            end else begin
                push_item(plan[i].op, plan[i].key, plan[i].pay, plan[i].typed,
                          plan[i].want);
            end
        end

        enq_pct = 50;
        foreach (phase_caps[p]) begin
            settle();
            write_cap(phase_caps[p]);
            for (int n = 0; n < PER_PHASE; n++) begin
                // swing between filling and draining to hit full and empty
                if (n % 30 == 0) begin
                    case ($urandom_range(0, 2))
                        0: enq_pct = 25;
                        1: enq_pct = 50;
                        default: enq_pct = 80;
                    endcase
                end
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                push_item(op, pick_key(), PW'($urandom), 1'b0,
                          '{0, 0, 0, ST_DONE, 0});
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sorted_insert_priority_queue_test: clean");
        end else begin
            $display("sorted_insert_priority_queue_test: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("sorted_insert_priority_queue_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sipq_pkg.sv
rtl/core/sipq_cell.sv
rtl/core/sorted_insert_priority_queue.sv
tb/sorted_insert_priority_queue_test.sv
